// ===== hw/rtl/bps_pkg.sv =====
// Shared types for the byte pair substitution decoder.
package bps_pkg;

    // How the emitter treats an accepted byte
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,   // header byte or escape marker: no decoded byte
        KIND_LIT  = 2'd1,   // escaped literal: copy as is
        KIND_LOOK = 2'd2    // data symbol: copy or expand per the pair table
    } bps_kind_t;

    typedef struct packed {
        bps_kind_t  kind;
        logic [7:0] data;
        logic       hit;    // table entry of data is valid in this block
        logic       last;   // final byte of the block
        logic       bad;    // block ended in the header or after an escape
    } bps_item_t;

endpackage

// ===== hw/rtl/byte_pair_substitution_decoder_top.sv =====
// After its input transfer a result passes the pair table read and held item,
// then the output register.
// Throughput: one input byte per cycle for header bytes, and for literal and
// copied bytes while the output accepts; a byte that expands yields two output
// bytes and is held until its second is emitted, so no new byte is taken before.
// Reset: rst_n clears the parser, valid marks, count and handshake state at
// once; the pair table RAM is not cleared and its data is used only behind a valid mark.
module byte_pair_substitution_decoder_top #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_of_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] block_total
    output logic        m_axis_tlast,   // block_end
    output logic [2:0]  m_axis_tuser    // [0] has_byte, [1] last_of_run, [2] bad_escape
);

    bps_pkg::bps_item_t item;
    logic        accept;
    logic        tbl_wr_en;
    logic [7:0]  tbl_wr_addr;
    logic [15:0] tbl_wr_data;
    logic        tbl_rd_en;
    logic [7:0]  tbl_rd_addr;
    logic [15:0] tbl_rd_data;
    logic [7:0]  out_byte;
    logic [31:0] out_total;
    logic        out_has;
    logic        out_run_last;
    logic        out_bad;

    assign accept = s_axis_tvalid && s_axis_tready;

    bps_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_axis_tdata),
        .last_of_block (s_axis_tlast),
        .item          (item),
        .tbl_wr_en     (tbl_wr_en),
        .tbl_wr_addr   (tbl_wr_addr),
        .tbl_wr_data   (tbl_wr_data),
        .tbl_rd_en     (tbl_rd_en),
        .tbl_rd_addr   (tbl_rd_addr)
    );

    bps_ram #(
        .WIDTH (16),
        .DEPTH (256)
    ) u_pair_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    bps_emitter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_item       (item),
        .tbl_data      (tbl_rd_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (out_byte),
        .out_has       (out_has),
        .out_run_last  (out_run_last),
        .out_block_end (m_axis_tlast),
        .out_total     (out_total),
        .out_bad       (out_bad)
    );

    assign m_axis_tdata = {out_total, out_byte};
    assign m_axis_tuser = {out_bad, out_run_last, out_has};

endmodule

// ===== hw/rtl/bps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module bps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bps_parser.sv =====
// Header parser and data-phase classifier; drives the pair table RAM.
module bps_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_of_block,
    output bps_pkg::bps_item_t  item,
    output logic                tbl_wr_en,
    output logic [7:0]          tbl_wr_addr,
    output logic [15:0]         tbl_wr_data,
    output logic                tbl_rd_en,
    output logic [7:0]          tbl_rd_addr
);

    typedef enum logic [7:0] {
        PH_H0   = 8'b0000_0001,
        PH_H1   = 8'b0000_0010,
        PH_H2   = 8'b0000_0100,
        PH_T0   = 8'b0000_1000,
        PH_T1   = 8'b0001_0000,
        PH_T2   = 8'b0010_0000,
        PH_ESC  = 8'b0100_0000,
        PH_DATA = 8'b1000_0000
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [7:0]   hold0_reg, hold0_next;
    logic [7:0]   hold1_reg, hold1_next;
    logic [7:0]   prev_reg, prev_next;
    logic         esc_en_reg, esc_en_next;
    logic [7:0]   esc_val_reg, esc_val_next;
    logic         esc_pend_reg, esc_pend_next;
    logic [255:0] valid_reg, valid_next;
    logic         wr_entry;

    always_comb
    begin
        phase_next    = phase_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        prev_next     = prev_reg;
        esc_en_next   = esc_en_reg;
        esc_val_next  = esc_val_reg;
        esc_pend_next = esc_pend_reg;
        valid_next    = valid_reg;
        wr_entry      = 1'b0;
        item.kind     = bps_pkg::KIND_NONE;
        item.data     = data_byte;
        item.hit      = valid_reg[data_byte];
        item.last     = last_of_block;

        case (phase_reg)
            PH_H0:
            begin
                hold0_next = data_byte;
                phase_next = PH_H1;
            end
            PH_H1:
            begin
                hold1_next = data_byte;
                phase_next = PH_H2;
            end
            PH_H2:
            begin
                // three equal leading bytes: no table
                if (hold0_reg == hold1_reg && hold1_reg == data_byte)
                begin
                    phase_next = PH_DATA;
                end
                else
                begin
                    wr_entry   = 1'b1;
                    prev_next  = hold0_reg;
                    phase_next = PH_T0;
                end
            end
            PH_T0:
            begin
                hold0_next = data_byte;
                phase_next = (data_byte == prev_reg) ? PH_ESC : PH_T1;
            end
            PH_T1:
            begin
                hold1_next = data_byte;
                phase_next = PH_T2;
            end
            PH_T2:
            begin
                wr_entry   = 1'b1;
                prev_next  = hold0_reg;
                phase_next = PH_T0;
            end
            PH_ESC:
            begin
                if (data_byte != hold0_reg)
                begin
                    esc_en_next  = 1'b1;
                    esc_val_next = data_byte;
                end
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (esc_pend_reg)
                begin
                    esc_pend_next = 1'b0;
                    item.kind     = bps_pkg::KIND_LIT;
                end
                else if (esc_en_reg && data_byte == esc_val_reg)
                begin
                    esc_pend_next = 1'b1;
                end
                else
                begin
                    item.kind = bps_pkg::KIND_LOOK;
                end
            end
            default:
            begin
                phase_next = PH_H0;
            end
        endcase

        if (wr_entry)
        begin
            valid_next[hold0_reg] = 1'b1;
        end

        item.bad = (phase_next != PH_DATA) || esc_pend_next;

        // block end: back to the reset state
        if (last_of_block)
        begin
            phase_next    = PH_H0;
            hold0_next    = 8'h00;
            hold1_next    = 8'h00;
            prev_next     = 8'h00;
            esc_en_next   = 1'b0;
            esc_val_next  = 8'h00;
            esc_pend_next = 1'b0;
            valid_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_H0;
            hold0_reg    <= 8'h00;
            hold1_reg    <= 8'h00;
            prev_reg     <= 8'h00;
            esc_en_reg   <= 1'b0;
            esc_val_reg  <= 8'h00;
            esc_pend_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            hold0_reg    <= hold0_next;
            hold1_reg    <= hold1_next;
            prev_reg     <= prev_next;
            esc_en_reg   <= esc_en_next;
            esc_val_reg  <= esc_val_next;
            esc_pend_reg <= esc_pend_next;
            valid_reg    <= valid_next;
        end
    end

    // Table writes happen only in the header and reads only in the data phase,
    // so a read always comes after the last write of its block.
    assign tbl_wr_en   = accept && wr_entry;
    assign tbl_wr_addr = hold0_reg;
    assign tbl_wr_data = {hold1_reg, data_byte};
    assign tbl_rd_en   = accept && (phase_reg == PH_DATA);
    assign tbl_rd_addr = data_byte;

endmodule

// ===== hw/rtl/bps_emitter.sv =====
// Expansion stage: turns a classified byte plus its table entry into results.
module bps_emitter #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bps_pkg::bps_item_t in_item,
    input  logic [15:0]        tbl_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_has,
    output logic               out_run_last,
    output logic               out_block_end,
    output logic [31:0]        out_total,
    output logic               out_bad
);

    localparam int TW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [TW-1:0]          TOT_MAX = TW'(32'hFFFF_FFFF);

    logic               s1_valid_reg;
    bps_pkg::bps_item_t s1_item_reg;
    logic               s1_second_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_has_reg;
    logic               out_run_last_reg;
    logic               out_block_end_reg;
    logic [31:0]        out_total_reg;
    logic               out_bad_reg;

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_after;
    logic [TW-1:0]          cnt_ext;

    logic       expand;
    logic       no_result;
    logic       final_res;
    logic       emit;
    logic       done;
    logic       res_has;
    logic [7:0] res_byte;
    logic       res_end;
    logic [31:0] res_total;

    always_comb
    begin
        expand    = (s1_item_reg.kind == bps_pkg::KIND_LOOK) && s1_item_reg.hit
                    && (tbl_data != {8'h00, s1_item_reg.data});
        no_result = (s1_item_reg.kind == bps_pkg::KIND_NONE) && !s1_item_reg.last;
        final_res = expand ? s1_second_reg : 1'b1;
        emit      = s1_valid_reg && !no_result && (!out_valid_reg || out_ready);
        done      = s1_valid_reg && (no_result || (emit && final_res));
        in_ready  = !s1_valid_reg || done;

        res_has = (s1_item_reg.kind != bps_pkg::KIND_NONE);
        if (!res_has)
        begin
            res_byte = 8'h00;
        end
        else if (expand)
        begin
            res_byte = s1_second_reg ? tbl_data[7:0] : tbl_data[15:8];
        end
        else
        begin
            res_byte = s1_item_reg.data;
        end
        res_end = s1_item_reg.last && final_res;

        cnt_after = (res_has && cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        cnt_ext   = TW'(cnt_after);
        res_total = (cnt_ext > TOT_MAX) ? 32'hFFFF_FFFF : cnt_ext[31:0];
        cnt_next  = res_end ? '0 : cnt_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                s1_second_reg <= !final_res;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
        if (emit)
        begin
            out_byte_reg      <= res_byte;
            out_has_reg       <= res_has;
            out_run_last_reg  <= final_res;
            out_block_end_reg <= res_end;
            out_total_reg     <= res_total;
            out_bad_reg       <= res_end && s1_item_reg.bad;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_has       = out_has_reg;
    assign out_run_last  = out_run_last_reg;
    assign out_block_end = out_block_end_reg;
    assign out_total     = out_total_reg;
    assign out_bad       = out_bad_reg;

    // second half of an expansion only while its item is still held
    a_second_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_second_reg |-> s1_valid_reg)
        else $error("second expansion byte without a held item");

    // no new item replaces one that still owes its second byte
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_second_reg && !done) |-> !in_ready)
        else $error("item accepted while expansion unfinished");

    // a block end result closes its run
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_block_end_reg) |-> out_run_last_reg)
        else $error("block end without end of run");

    // bare markers and error flags appear only at block end
    a_flags_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (!out_has_reg || out_bad_reg)) |-> out_block_end_reg)
        else $error("bare or bad result away from block end");

    // count restarts after a block end
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_end) |=> (cnt_reg == '0))
        else $error("decoded count not cleared at block end");

endmodule
